// File: src/smse_pkg.sv
// ============================================================================
// smse_pkg
// Shared types and constants of the stable merge sort engine: channel
// payloads, the stored record, controller states and the command and status
// bundles between controller and datapath.
// ============================================================================
package smse_pkg;

   localparam int KEY_BITS            = 32;
   localparam int TAG_BITS            = 16;
   localparam int MAX_RECORDS_DEFAULT = 64;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int CSR_DATA_BITS       = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DESCENDING  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED_KEYS = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
      logic                last_in;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] sorted_key;
      logic [TAG_BITS-1:0] sorted_tag;
      logic                last_out;
      logic                dropped;
   } rsp_payload_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } record_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PREP,
      ST_SORT,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic out_en;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sort_needed;
      logic sort_done;
      logic out_last;
   } dp_status_type;

endpackage

// File: src/stable_merge_sort_engine.sv
// ============================================================================
// stable_merge_sort_engine
// Collects a set of key/tag records and returns them in stable sorted order,
// using bottom-up merge sort between two ping-pong record buffers.
// ============================================================================
//
//   Channel  Direction  Handshake          Carries
//   req_     in         valid / stall      one record per transfer, last_in ends the set
//   rsp_     out        valid / stall      one sorted record per transfer, last_out ends it
//   csr_     in         valid / ready      register index and write data
//
// A set of n records is loaded, set up, merged in ceil(log2 n) passes (one
// record written per cycle by the single comparator) and then emitted.
// Reset clears the controller, the record count, the overflow flag and the
// result valid; the buffers are not cleared. A stall on rsp_ holds the
// result register and pauses output; the next set may start loading while
// the final result of the previous set still waits.
//
module stable_merge_sort_engine import smse_pkg::*; #(
   parameter int MAX_RECORDS = MAX_RECORDS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers. Writes must arrive only between sets; the block
   // does not enforce this, and the comparator uses them throughout a sort.
   logic descending_ff, descending_in;
   logic signed_keys_ff, signed_keys_in;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The register port never holds off a transfer; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      descending_in  = descending_ff;
      signed_keys_in = signed_keys_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DESCENDING:  descending_in  = csr_wdata[0];
            CSR_SIGNED_KEYS: signed_keys_in = csr_wdata[0];
            default: begin
               descending_in = descending_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff  <= 1'b0;
         signed_keys_ff <= 1'b0;
      end else begin
         descending_ff  <= descending_in;
         signed_keys_ff <= signed_keys_in;
      end
   end

   // The controller sequences the phases; it sees only the handshake and the
   // datapath's status.
   smse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_in),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // The datapath holds both buffers, the merge pointers, the comparator and
   // the result register that decouples the output stall from the sort.
   smse_datapath #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .descending  (descending_ff),
      .signed_keys (signed_keys_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: src/smse_datapath.sv
// ============================================================================
// smse_datapath
// Record buffers, merge pointers, key comparator and the result register of
// the stable merge sort engine.
// ============================================================================
module smse_datapath import smse_pkg::*; #(
   parameter int MAX_RECORDS = MAX_RECORDS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   input  logic            descending,
   input  logic            signed_keys,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int W_W   = CNT_W + 1;
   localparam int SUM_W = W_W + 1;

   // True when the record with key l must come strictly after the one with key r.
   function automatic logic goes_after(input logic [KEY_BITS-1:0] l,
                                       input logic [KEY_BITS-1:0] r,
                                       input logic                desc,
                                       input logic                sgn);
      logic [KEY_BITS-1:0] lf;
      logic [KEY_BITS-1:0] rf;
      lf = l;
      rf = r;
      lf[KEY_BITS-1] = l[KEY_BITS-1] ^ sgn;
      rf[KEY_BITS-1] = r[KEY_BITS-1] ^ sgn;
      return desc ? (lf < rf) : (lf > rf);
   endfunction

   // min(base + step, n)
   function automatic logic [CNT_W-1:0] clip_add(input logic [CNT_W-1:0] base,
                                                 input logic [W_W-1:0]   step,
                                                 input logic [CNT_W-1:0] n);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(step);
      return (sum < SUM_W'(n)) ? CNT_W'(sum) : n;
   endfunction

   record_type mem_a [MAX_RECORDS];
   record_type mem_b [MAX_RECORDS];

   record_type rd_al_ff, rd_ar_ff, rd_bl_ff, rd_br_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] l_ff, l_in;
   logic [CNT_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] o_ff, o_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [W_W-1:0]   w_ff, w_in;
   logic             src_ff, src_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   record_type       rec_l, rec_r, rec_w, wr_data;
   logic             take_r;
   logic [CNT_W-1:0] o_next;
   logic [W_W-1:0]   w_dbl;
   logic             run_end, pass_end, load_store, out_fire;
   logic             we_a, we_b;
   logic [IDX_W-1:0] wr_addr, rd_addr_l, rd_addr_r;

   always_comb begin
      rec_l    = src_ff ? rd_bl_ff : rd_al_ff;
      rec_r    = src_ff ? rd_br_ff : rd_ar_ff;
      take_r   = (l_ff >= mid_ff) ||
                 ((r_ff < hi_ff) && goes_after(rec_l.key, rec_r.key, descending, signed_keys));
      rec_w    = take_r ? rec_r : rec_l;
      o_next   = o_ff + CNT_W'(1);
      w_dbl    = w_ff << 1;
      run_end  = (o_next == hi_ff);
      pass_end = run_end && (hi_ff == count_ff);
      load_store = cmd.load && (count_ff < CNT_W'(MAX_RECORDS));
      out_fire = cmd.out_en && (!rsp_valid_ff || !rsp_stall) && (l_ff != count_ff);
   end

   always_comb begin
      status.sort_needed = (count_ff > CNT_W'(1));
      status.sort_done   = cmd.step && pass_end && (w_dbl >= W_W'(count_ff));
      status.out_last    = out_fire && ((l_ff + CNT_W'(1)) == count_ff);
   end

   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      l_in           = l_ff;
      r_in           = r_ff;
      o_in           = o_ff;
      mid_in         = mid_ff;
      hi_in          = hi_ff;
      w_in           = w_ff;
      src_in         = src_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      priority if (cmd.load) begin
         if (load_store) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end else if (cmd.prep) begin
         w_in   = W_W'(1);
         src_in = 1'b0;
         l_in   = '0;
         o_in   = '0;
         mid_in = clip_add('0, W_W'(1), count_ff);
         hi_in  = clip_add(mid_in, W_W'(1), count_ff);
         r_in   = mid_in;
      end else if (cmd.step) begin
         if (take_r) begin
            r_in = r_ff + CNT_W'(1);
         end else begin
            l_in = l_ff + CNT_W'(1);
         end
         o_in = o_next;
         if (pass_end) begin
            w_in   = w_dbl;
            src_in = !src_ff;
            l_in   = '0;
            o_in   = '0;
            mid_in = clip_add('0, w_dbl, count_ff);
            hi_in  = clip_add(mid_in, w_dbl, count_ff);
            r_in   = mid_in;
         end else if (run_end) begin
            l_in   = hi_ff;
            mid_in = clip_add(hi_ff, w_ff, count_ff);
            hi_in  = clip_add(mid_in, w_ff, count_ff);
            r_in   = mid_in;
         end
      end else if (out_fire) begin
         l_in                      = l_ff + CNT_W'(1);
         rsp_valid_in              = 1'b1;
         rsp_payload_in.sorted_key = rec_l.key;
         rsp_payload_in.sorted_tag = rec_l.tag;
         rsp_payload_in.last_out   = status.out_last;
         rsp_payload_in.dropped    = overflow_ff;
         if (status.out_last) begin
            count_in    = '0;
            overflow_in = 1'b0;
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         l_ff         <= '0;
         r_ff         <= '0;
         o_ff         <= '0;
         mid_ff       <= '0;
         hi_ff        <= '0;
         w_ff         <= W_W'(1);
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         l_ff         <= l_in;
         r_ff         <= r_in;
         o_ff         <= o_in;
         mid_ff       <= mid_in;
         hi_ff        <= hi_in;
         w_ff         <= w_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // Buffers: one write port, two registered read ports each. A read of the
   // entry being written in the same cycle returns the new record.
   always_comb begin
      we_a      = load_store || (cmd.step && src_ff);
      we_b      = cmd.step && !src_ff;
      wr_addr   = cmd.load ? count_ff[IDX_W-1:0] : o_ff[IDX_W-1:0];
      wr_data   = cmd.load ? record_type'{key: req_payload.key, tag: req_payload.tag} : rec_w;
      rd_addr_l = l_in[IDX_W-1:0];
      rd_addr_r = r_in[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_al_ff <= (we_a && (wr_addr == rd_addr_l)) ? wr_data : mem_a[rd_addr_l];
      rd_ar_ff <= (we_a && (wr_addr == rd_addr_r)) ? wr_data : mem_a[rd_addr_r];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_bl_ff <= (we_b && (wr_addr == rd_addr_l)) ? wr_data : mem_b[rd_addr_l];
      rd_br_ff <= (we_b && (wr_addr == rd_addr_r)) ? wr_data : mem_b[rd_addr_r];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: src/smse_ctrl.sv
// ============================================================================
// smse_ctrl
// Phase controller of the stable merge sort engine: load, set-up, merge
// passes and result output.
// ============================================================================
module smse_ctrl import smse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          req_stall
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = status.sort_needed ? ST_SORT : ST_OUT;
         end
         ST_SORT: begin
            if (status.sort_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_SORT: begin
            cmd.step = 1'b1;
         end
         ST_OUT: begin
            cmd.out_en = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sim/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the stable merge sort engine. Record sets of
// directed and random content are pushed through the request channel with
// bursty timing. An independent stable sort predicts every sorted record,
// which is compared field by field with each result transfer while the
// receiver stalls on a changing pattern.
// ============================================================================
module testbench;
   import smse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAPACITY      = MAX_RECORDS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned PHASE_RECORDS = 60;

   // Indexes beyond the register list; the block must ignore writes to them.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_TWO   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_THREE = CSR_INDEX_BITS'(3);

   // Every input has a known value from time zero, well before reset ends.
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata   = '0;

   // Records waiting to be presented, and sorted records still to arrive.
   req_payload_type pending_records[$];
   rsp_payload_type sorted_expected[$];

   // Shadow of the block: the registers and the set being collected.
   logic              order_descending = 1'b0;
   logic              keys_signed      = 1'b0;
   record_type        held_records[CAPACITY];
   int unsigned       held_count       = 0;
   logic              capacity_lost    = 1'b0;

   int unsigned       failures         = 0;
   int unsigned       records_accepted = 0;
   int unsigned       sets_accepted    = 0;
   int unsigned       overflow_sets    = 0;
   int unsigned       results_checked  = 0;
   int unsigned       cycle_count      = 0;
   rsp_payload_type   due_result;

   // Sender burst state and receiver stall pattern.
   int unsigned       burst_left = 0;
   int unsigned       gap_left   = 0;
   int unsigned       stall_step = 0;
   logic [15:0]       stall_pattern = '0;

   stable_merge_sort_engine #(
      .MAX_RECORDS (CAPACITY)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Ordering and prediction
   // ------------------------------------------------------------------------

   // True when a record keyed left must be placed strictly after one keyed
   // right. Signed keys are compared by flipping the sign bit, which maps
   // two's complement order onto unsigned order.
   function automatic logic ranks_after(logic [KEY_BITS-1:0] left,
                                        logic [KEY_BITS-1:0] right);
      logic [KEY_BITS-1:0] flip;
      flip = keys_signed ? {1'b1, {(KEY_BITS-1){1'b0}}} : '0;
      left  = left ^ flip;
      right = right ^ flip;
      return order_descending ? (left < right) : (left > right);
   endfunction

   // Sorts the held set with a stable insertion sort. Any stable sort under
   // the same strict ordering gives exactly the order of a stable merge sort,
   // so equal keys keep their arrival order. Every record becomes one
   // expected result, all flagged when the set lost records to capacity.
   task automatic predict_sorted_set();
      record_type      ordered[CAPACITY];
      record_type      moving;
      int              j;
      rsp_payload_type item;
      for (int i = 0; i < held_count; i++) begin
         ordered[i] = held_records[i];
      end
      for (int i = 1; i < held_count; i++) begin
         moving = ordered[i];
         j = i;
         while (j > 0 && ranks_after(ordered[j-1].key, moving.key)) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = moving;
      end
      for (int i = 0; i < held_count; i++) begin
         item.sorted_key = ordered[i].key;
         item.sorted_tag = ordered[i].tag;
         item.last_out   = (i == held_count - 1);
         item.dropped    = capacity_lost;
         sorted_expected.push_back(item);
      end
   endtask

   task automatic check_field(string field, logic [KEY_BITS-1:0] want,
                              logic [KEY_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents queued records in bursts of random length separated by
   // random gaps. A new record is only put up once the previous one has been
   // transferred, so a stalled payload never changes.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_records.size() > 0) begin
            req_valid   <= 1'b1;
            req_payload <= pending_records.pop_front();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            if (burst_left == 0) begin
               // A quarter of bursts run straight into the next one.
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stalls on a 16-bit pattern that is played three times over
   // before it is redrawn. A quarter of the patterns never stall; bit zero is
   // always clear so that results keep flowing.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_step = 0;
      end else begin
         if (stall_step == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0000
                                                        : 16'($urandom) & 16'hFFFE;
         end
         rsp_stall <= stall_pattern[stall_step % 16];
         stall_step = (stall_step + 1) % 48;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: follows register writes and request transfers into the shadow
   // state, predicts each set when its last record is transferred, and
   // checks every result transfer against the oldest prediction. All values
   // are sampled at the rising edge, before any update from that edge lands.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DESCENDING:  order_descending = csr_wdata[0];
               CSR_SIGNED_KEYS: keys_signed      = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            records_accepted++;
            if (held_count < CAPACITY) begin
               held_records[held_count] = '{key: req_payload.key, tag: req_payload.tag};
               held_count++;
            end else begin
               capacity_lost = 1'b1;
            end
            // The last record starts the sort even when it found no room.
            if (req_payload.last_in) begin
               predict_sorted_set();
               sets_accepted++;
               if (capacity_lost) begin
                  overflow_sets++;
               end
               held_count    = 0;
               capacity_lost = 1'b0;
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (sorted_expected.size() == 0) begin
               $display("%0t: result transfer with nothing expected: expected none, actual %h",
                        $time, rsp_payload);
               failures++;
            end else begin
               due_result = sorted_expected.pop_front();
               check_field("sorted_key", due_result.sorted_key, rsp_payload.sorted_key);
               check_field("sorted_tag", KEY_BITS'(due_result.sorted_tag),
                           KEY_BITS'(rsp_payload.sorted_tag));
               check_field("last_out", KEY_BITS'(due_result.last_out),
                           KEY_BITS'(rsp_payload.last_out));
               check_field("dropped", KEY_BITS'(due_result.dropped),
                           KEY_BITS'(rsp_payload.dropped));
               results_checked++;
            end
         end
      end
   end

   // A run that stops making progress ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  sorted_expected.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic queue_record(logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag,
                               logic last_in);
      pending_records.push_back(req_payload_type'{key: key, tag: tag, last_in: last_in});
   endtask

   // Keys are drawn so that duplicates are common, the sign boundary and the
   // top of the range are visited often, and every bit takes both values.
   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0:       return KEY_BITS'($urandom_range(0, 7));
         1:       return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFF8)
                         + KEY_BITS'($urandom_range(0, 7));
         2:       return 32'hFFFF_FFF8 + KEY_BITS'($urandom_range(0, 7));
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   task automatic queue_random_set(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         queue_record(pick_key(), TAG_BITS'($urandom), i == count - 1);
      end
   endtask

   // Holds the sender back until every queued record has been transferred
   // and every predicted result has arrived, then lets the block settle.
   // Checked on the falling edge, when the monitor's updates have landed.
   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (pending_records.size() != 0 || req_valid || sorted_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random phase: new register settings, then sets of random length,
   // mostly short, until the phase has its share of records. A forced set
   // length, when given, comes first.
   task automatic run_random_phase(logic descending, logic signed_keys,
                                   int unsigned forced_length);
      int unsigned queued;
      int unsigned length;
      write_register(CSR_DESCENDING, descending);
      write_register(CSR_SIGNED_KEYS, signed_keys);
      queued = 0;
      if (forced_length != 0) begin
         queue_random_set(forced_length);
         queued = forced_length;
      end
      while (queued < PHASE_RECORDS) begin
         length = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
         queue_random_set(length);
         queued += length;
      end
      wait_for_drain();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // Registers written explicitly at their reset values; writes to the
      // spare indexes must leave them alone.
      write_register(CSR_DESCENDING, 1'b0);
      write_register(CSR_SIGNED_KEYS, 1'b0);
      write_register(CSR_SPARE_TWO, 1'b1);
      write_register(CSR_SPARE_THREE, 1'b1);

      // Directed, ascending unsigned: a set of one record, a pair of equal
      // keys that must keep their order, and the extremes of key and tag.
      queue_record(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      queue_record(32'h0000_0005, 16'h0001, 1'b0);
      queue_record(32'h0000_0005, 16'h0002, 1'b1);
      queue_record(32'h8000_0000, 16'h0001, 1'b0);
      queue_record(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
      queue_record(32'h0000_0000, 16'h0000, 1'b0);
      queue_record(32'hFFFF_FFFF, 16'h8000, 1'b0);
      queue_record(32'h8000_0000, 16'h0002, 1'b0);
      queue_record(32'h0000_0001, 16'h7FFF, 1'b1);
      wait_for_drain();

      // Directed, descending signed: the same extremes, then three equal
      // keys of minus one that must come out in arrival order.
      write_register(CSR_DESCENDING, 1'b1);
      write_register(CSR_SIGNED_KEYS, 1'b1);
      queue_record(32'h0000_0000, 16'hAAAA, 1'b0);
      queue_record(32'h8000_0000, 16'h5555, 1'b0);
      queue_record(32'hFFFF_FFFF, 16'h0F0F, 1'b0);
      queue_record(32'h7FFF_FFFF, 16'hF0F0, 1'b0);
      queue_record(32'h0000_0001, 16'h00FF, 1'b0);
      queue_record(32'h7FFF_FFFF, 16'hFF00, 1'b1);
      queue_record(32'hFFFF_FFFF, 16'h000A, 1'b0);
      queue_record(32'hFFFF_FFFF, 16'h000B, 1'b0);
      queue_record(32'hFFFF_FFFF, 16'h000C, 1'b1);
      wait_for_drain();

      // Random phases across all four settings. One fills the buffers
      // exactly; another overruns them so that records are dropped, the last
      // record possibly among them.
      run_random_phase(1'b1, 1'b0, CAPACITY);
      run_random_phase(1'b0, 1'b1, $urandom_range(CAPACITY + 1, CAPACITY + 8));
      run_random_phase(1'b1, 1'b1, 0);
      run_random_phase(1'b0, 1'b0, 0);

      $display("Covered %0d records in %0d sets, %0d of them over capacity,",
               records_accepted, sets_accepted, overflow_sets);
      $display("under all four orderings; %0d sorted results checked, %0d failures.",
               results_checked, failures);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: stable_merge_sort_engine.f
src/smse_pkg.sv
src/smse_datapath.sv
src/smse_ctrl.sv
src/stable_merge_sort_engine.sv
sim/testbench.sv
